// ===== sv/tcw_pkg.sv =====
// Shared types, codes and constants for the text console writer.
package tcw_pkg;

   localparam int DEF_SCREEN_WIDTH  = 80;
   localparam int DEF_SCREEN_HEIGHT = 25;

   localparam int OP_W     = 2;
   localparam int CHAR_W   = 8;
   localparam int X_W      = 7;
   localparam int Y_W      = 5;
   localparam int INDEX_W  = 11;
   localparam int OFFSET_W = 11;
   localparam int CELL_W   = 16;
   localparam int ATTR_W   = 8;

   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_SET   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
   localparam logic [OP_W-1:0] OP_READ  = 2'd3;

   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;

   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0700;
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [CHAR_W-1:0]  char_code;
      logic [X_W-1:0]     new_x;
      logic [Y_W-1:0]     new_y;
      logic [INDEX_W-1:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [X_W-1:0]      cursor_x;
      logic [Y_W-1:0]      cursor_y;
      logic [OFFSET_W-1:0] cursor_offset;
      logic [CELL_W-1:0]   read_data;
   } rsp_type;

endpackage

// ===== sv/tcw_screen_ram.sv =====
// Screen cell memory: one write port and one registered read port.
module tcw_screen_ram #(
   parameter int DEPTH  = tcw_pkg::DEF_SCREEN_WIDTH * tcw_pkg::DEF_SCREEN_HEIGHT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [tcw_pkg::CELL_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [tcw_pkg::CELL_W-1:0]  rd_data
);

   logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
   logic [tcw_pkg::CELL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rdata_ff;

endmodule

// ===== sv/tcw_engine.sv =====
// Console sequencer: cursor state, cell writes, scroll copy and fill sweeps.
module tcw_engine #(
   parameter int SCREEN_WIDTH  = tcw_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = tcw_pkg::DEF_SCREEN_HEIGHT,
   parameter int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT,
   parameter int ADDR_W        = $clog2(CELL_COUNT)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  tcw_pkg::req_type            req,
   output logic                        req_ready,
   input  logic [tcw_pkg::ATTR_W-1:0]  color_attr,
   output logic                        res_valid,
   output tcw_pkg::rsp_type            res,
   input  logic                        res_take,
   output logic                        ram_wr_en,
   output logic [ADDR_W-1:0]           ram_wr_addr,
   output logic [tcw_pkg::CELL_W-1:0]  ram_wr_data,
   output logic                        ram_rd_en,
   output logic [ADDR_W-1:0]           ram_rd_addr,
   input  logic [tcw_pkg::CELL_W-1:0]  ram_rd_data
);

   localparam int COL_W = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
   localparam int ROW_W = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
   localparam int CNT_W = $clog2(CELL_COUNT + 1);
   localparam int MOVE_COUNT = SCREEN_WIDTH * (SCREEN_HEIGHT - 1);

   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(SCREEN_WIDTH - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SCREEN_HEIGHT - 1);
   localparam logic [ADDR_W-1:0] WIDTH_A   = ADDR_W'(SCREEN_WIDTH);
   localparam logic [CNT_W-1:0]  WIDTH_C   = CNT_W'(SCREEN_WIDTH);
   localparam logic [CNT_W-1:0]  MOVE_C    = CNT_W'(MOVE_COUNT);
   localparam logic [CNT_W-1:0]  LAST_CELL = CNT_W'(CELL_COUNT - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;
   localparam logic [2:0] ST_SCROLL = 3'd2;
   localparam logic [2:0] ST_FILL   = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              report_ff, report_in;
   tcw_pkg::req_type  req_ff, req_in;

   logic [ADDR_W-1:0] pos;
   logic [CNT_W-1:0]  src_cnt;
   logic [CNT_W-1:0]  dst_cnt;
   logic [31:0]       idx_wide;
   logic [31:0]       x_wide;
   logic [31:0]       y_wide;
   logic [31:0]       off_wide;
   logic              idx_ok;

   assign pos      = ADDR_W'(row_ff) * WIDTH_A + ADDR_W'(col_ff);
   assign src_cnt  = cnt_ff + WIDTH_C;
   assign dst_cnt  = cnt_ff - CNT_W'(1);
   assign idx_wide = 32'(req_ff.cell_index);
   assign idx_ok   = idx_wide < 32'(CELL_COUNT);
   assign x_wide   = 32'(col_ff);
   assign y_wide   = 32'(row_ff);
   assign off_wide = 32'(pos);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      report_in   = report_ff;
      req_in      = req_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = pos;
      ram_wr_data = tcw_pkg::BLANK_CELL;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_wide[ADDR_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            unique case (req_ff.op)
               tcw_pkg::OP_PUT: begin
                  priority if (req_ff.char_code == tcw_pkg::CH_NEWLINE) begin
                     col_in = '0;
                     if (row_ff == LAST_ROW) begin
                        cnt_in   = '0;
                        state_in = ST_SCROLL;
                     end else begin
                        row_in = row_ff + ROW_W'(1);
                     end
                  end else if (req_ff.char_code == tcw_pkg::CH_BACKSPACE) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = {color_attr, 8'h00};
                     if (col_ff != '0) begin
                        col_in = col_ff - COL_W'(1);
                     end else if (row_ff != '0) begin
                        row_in = row_ff - ROW_W'(1);
                        col_in = LAST_COL;
                     end
                  end else if (req_ff.char_code == tcw_pkg::CH_RETURN) begin
                     col_in = LAST_COL;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = {color_attr, req_ff.char_code};
                     if (col_ff == LAST_COL) begin
                        col_in = '0;
                        if (row_ff == LAST_ROW) begin
                           cnt_in   = '0;
                           state_in = ST_SCROLL;
                        end else begin
                           row_in = row_ff + ROW_W'(1);
                        end
                     end else begin
                        col_in = col_ff + COL_W'(1);
                     end
                  end
               end
               tcw_pkg::OP_SET: begin
                  if (32'(req_ff.new_x) > 32'(SCREEN_WIDTH - 1)) begin
                     col_in = LAST_COL;
                  end else begin
                     col_in = COL_W'(req_ff.new_x);
                  end
                  if (32'(req_ff.new_y) > 32'(SCREEN_HEIGHT - 1)) begin
                     row_in = LAST_ROW;
                  end else begin
                     row_in = ROW_W'(req_ff.new_y);
                  end
               end
               tcw_pkg::OP_CLEAR: begin
                  col_in    = '0;
                  row_in    = '0;
                  cnt_in    = '0;
                  report_in = 1'b1;
                  state_in  = ST_FILL;
               end
               tcw_pkg::OP_READ: begin
                  ram_rd_en = idx_ok;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_SCROLL: begin
            ram_rd_en   = cnt_ff < MOVE_C;
            ram_rd_addr = src_cnt[ADDR_W-1:0];
            ram_wr_en   = cnt_ff != '0;
            ram_wr_addr = dst_cnt[ADDR_W-1:0];
            ram_wr_data = ram_rd_data;
            if (cnt_ff == MOVE_C) begin
               report_in = 1'b1;
               state_in  = ST_FILL;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_FILL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_ff[ADDR_W-1:0];
            if (cnt_ff == LAST_CELL) begin
               state_in = report_ff ? ST_DONE : ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_FILL;
         cnt_ff    <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         report_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         report_ff <= report_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   assign req_ready = state_ff == ST_IDLE;
   assign res_valid = state_ff == ST_DONE;

   always_comb begin
      res.cursor_x      = x_wide[tcw_pkg::X_W-1:0];
      res.cursor_y      = y_wide[tcw_pkg::Y_W-1:0];
      res.cursor_offset = off_wide[tcw_pkg::OFFSET_W-1:0];
      if (req_ff.op == tcw_pkg::OP_READ && idx_ok) begin
         res.read_data = ram_rd_data;
      end else begin
         res.read_data = '0;
      end
   end

endmodule

// ===== sv/text_console_writer.sv =====
// Text console writer top level: stream ports, attribute register, result register.
//
// A screen of SCREEN_WIDTH x SCREEN_HEIGHT attribute/character cells held in one
// single-port-write, registered-read memory, with a cursor. After reset the block
// sweeps every cell to 0x0700, one cell a cycle, with req_tready low. Put, set
// cursor and read cell pass through the execute and done states, then the result
// register. A put that moves past the bottom row scrolls through the same memory:
// one cell copied per cycle, then the bottom row refilled. Clear screen homes the
// cursor and sweeps every cell to 0x0700. One op is in flight at a time; the next
// beat is taken while a result still waits in the output register.
// csr_wr_en/csr_wr_data write the attribute byte.
module text_console_writer #(
   parameter int SCREEN_WIDTH  = tcw_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = tcw_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // char_code[7:0], new_x[14:8], new_y[19:15], cell_index[30:20], zero[31]
   input  logic [31:0] req_tdata,
   // op[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cursor_x[6:0], cursor_y[11:7], cursor_offset[22:12], read_data[38:23], zero[39]
   output logic [39:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   logic [tcw_pkg::ATTR_W-1:0] attr_ff, attr_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [39:0]                rsp_data_ff, rsp_data_in;

   tcw_pkg::req_type           req;
   tcw_pkg::rsp_type           res;
   logic                       res_valid;
   logic                       res_take;
   logic                       ram_wr_en;
   logic [ADDR_W-1:0]          ram_wr_addr;
   logic [tcw_pkg::CELL_W-1:0] ram_wr_data;
   logic                       ram_rd_en;
   logic [ADDR_W-1:0]          ram_rd_addr;
   logic [tcw_pkg::CELL_W-1:0] ram_rd_data;

   always_comb begin
      req.op         = req_tuser;
      req.char_code  = req_tdata[7:0];
      req.new_x      = req_tdata[14:8];
      req.new_y      = req_tdata[19:15];
      req.cell_index = req_tdata[30:20];
   end

   tcw_engine #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .CELL_COUNT    (CELL_COUNT),
      .ADDR_W        (ADDR_W)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req         (req),
      .req_ready   (req_tready),
      .color_attr  (attr_ff),
      .res_valid   (res_valid),
      .res         (res),
      .res_take    (res_take),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   tcw_screen_ram #(
      .DEPTH  (CELL_COUNT),
      .ADDR_W (ADDR_W)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      attr_in      = csr_wr_en ? csr_wr_data : attr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, res.read_data, res.cursor_offset, res.cursor_y, res.cursor_x};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= tcw_pkg::ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         attr_ff      <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== tb/text_console_writer_test.sv =====
// Testbench for text_console_writer: directed table and random console ops checked against a screen model.
`timescale 1ns / 1ps

module text_console_writer_test;
   import tcw_pkg::*;

   localparam int COLS         = DEF_SCREEN_WIDTH;
   localparam int ROWS         = DEF_SCREEN_HEIGHT;
   localparam int CELLS        = COLS * ROWS;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 272;
   localparam int SCROLL_CAP   = 120;
   localparam int CLEAR_CAP    = 30;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int DIR_ROWS     = 25;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [CHAR_W-1:0]   ch;
      logic [X_W-1:0]      x;
      logic [Y_W-1:0]      y;
      logic [INDEX_W-1:0]  idx;
      logic                typed;
      logic [X_W-1:0]      wx;
      logic [Y_W-1:0]      wy;
      logic [OFFSET_W-1:0] woff;
      logic [CELL_W-1:0]   wdata;
   } stim_row_t;

   localparam stim_row_t DIRECTED [DIR_ROWS] = '{
      '{OP_READ,  8'h00,        7'd0,   5'd0,  11'd0,    1'b1, 7'd0,  5'd0,  11'd0,    16'h0700},
      '{OP_READ,  8'h00,        7'd0,   5'd0,  11'd1999, 1'b1, 7'd0,  5'd0,  11'd0,    16'h0700},
      '{OP_READ,  8'h00,        7'd0,   5'd0,  11'd2047, 1'b1, 7'd0,  5'd0,  11'd0,    16'h0000},
      '{OP_PUT,   8'h41,        7'd0,   5'd0,  11'd0,    1'b1, 7'd1,  5'd0,  11'd1,    16'h0000},
      '{OP_READ,  8'h00,        7'd0,   5'd0,  11'd0,    1'b1, 7'd1,  5'd0,  11'd1,    16'h0741},
      '{OP_PUT,   CH_BACKSPACE, 7'd0,   5'd0,  11'd0,    1'b1, 7'd0,  5'd0,  11'd0,    16'h0000},
      '{OP_PUT,   CH_BACKSPACE, 7'd0,   5'd0,  11'd0,    1'b1, 7'd0,  5'd0,  11'd0,    16'h0000},
      '{OP_READ,  8'h00,        7'd0,   5'd0,  11'd0,    1'b1, 7'd0,  5'd0,  11'd0,    16'h0700},
      '{OP_SET,   8'h00,        7'd127, 5'd31, 11'd0,    1'b1, 7'd79, 5'd24, 11'd1999, 16'h0000},
      '{OP_PUT,   CH_RETURN,    7'd0,   5'd0,  11'd0,    1'b1, 7'd79, 5'd24, 11'd1999, 16'h0000},
      '{OP_PUT,   8'hFF,        7'd0,   5'd0,  11'd0,    1'b1, 7'd0,  5'd24, 11'd1920, 16'h0000},
      '{OP_READ,  8'h00,        7'd0,   5'd0,  11'd1919, 1'b1, 7'd0,  5'd24, 11'd1920, 16'h07FF},
      '{OP_READ,  8'h00,        7'd0,   5'd0,  11'd1999, 1'b1, 7'd0,  5'd24, 11'd1920, 16'h0700},
      '{OP_PUT,   CH_NEWLINE,   7'd0,   5'd0,  11'd0,    1'b1, 7'd0,  5'd24, 11'd1920, 16'h0000},
      '{OP_READ,  8'h00,        7'd0,   5'd0,  11'd1839, 1'b1, 7'd0,  5'd24, 11'd1920, 16'h07FF},
      '{OP_SET,   8'h00,        7'd0,   5'd0,  11'd0,    1'b1, 7'd0,  5'd0,  11'd0,    16'h0000},
      '{OP_PUT,   8'h00,        7'd0,   5'd0,  11'd0,    1'b0, 7'd0,  5'd0,  11'd0,    16'h0000},
      '{OP_PUT,   8'h80,        7'd0,   5'd0,  11'd0,    1'b0, 7'd0,  5'd0,  11'd0,    16'h0000},
      '{OP_PUT,   CH_NEWLINE,   7'd0,   5'd0,  11'd0,    1'b1, 7'd0,  5'd1,  11'd80,   16'h0000},
      '{OP_SET,   8'h00,        7'd79,  5'd24, 11'd0,    1'b0, 7'd0,  5'd0,  11'd0,    16'h0000},
      '{OP_SET,   8'h00,        7'd0,   5'd2,  11'd0,    1'b0, 7'd0,  5'd0,  11'd0,    16'h0000},
      '{OP_PUT,   CH_BACKSPACE, 7'd0,   5'd0,  11'd0,    1'b0, 7'd0,  5'd0,  11'd0,    16'h0000},
      '{OP_READ,  8'h00,        7'd0,   5'd0,  11'd1,    1'b0, 7'd0,  5'd0,  11'd0,    16'h0000},
      '{OP_CLEAR, 8'h00,        7'd0,   5'd0,  11'd0,    1'b1, 7'd0,  5'd0,  11'd0,    16'h0000},
      '{OP_READ,  8'h00,        7'd0,   5'd0,  11'd0,    1'b1, 7'd0,  5'd0,  11'd0,    16'h0700}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   logic [CELL_W-1:0] screen_model [CELLS];
   int                cur_col;
   int                cur_row;
   logic [ATTR_W-1:0] attr_reg;
   int                scroll_count;
   int                clear_count;
   rsp_type           pending_rsp [$];
   int                mismatch_count;
   int                cycle_count;
   bit                quiet;
   bit                hold_request;
   rsp_type           got_rsp;
   rsp_type           want_rsp;

   text_console_writer uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic blank_screen();
      for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
      cur_col = 0;
      cur_row = 0;
   endtask

   task automatic advance_line();
      cur_col = 0;
      cur_row++;
      if (cur_row >= ROWS) begin
         for (int i = 0; i < CELLS - COLS; i++) screen_model[i] = screen_model[i + COLS];
         for (int i = CELLS - COLS; i < CELLS; i++) screen_model[i] = BLANK_CELL;
         cur_row = ROWS - 1;
         scroll_count++;
      end
   endtask

   task automatic console_apply(input req_type item, output rsp_type result);
      int pos;
      logic [CELL_W-1:0] data;
      data = '0;
      case (item.op)
         OP_PUT: begin
            pos = cur_row * COLS + cur_col;
            if (item.char_code == CH_NEWLINE) begin
               advance_line();
            end else if (item.char_code == CH_BACKSPACE) begin
               screen_model[pos] = {attr_reg, 8'h00};
               if (cur_col != 0) begin
                  cur_col--;
               end else if (cur_row != 0) begin
                  cur_row--;
                  cur_col = COLS - 1;
               end
            end else if (item.char_code == CH_RETURN) begin
               cur_col = COLS - 1;
            end else begin
               screen_model[pos] = {attr_reg, item.char_code};
               cur_col++;
               if (cur_col >= COLS) advance_line();
            end
         end
         OP_SET: begin
            cur_col = (int'(item.new_x) > COLS - 1) ? COLS - 1 : int'(item.new_x);
            cur_row = (int'(item.new_y) > ROWS - 1) ? ROWS - 1 : int'(item.new_y);
         end
         OP_CLEAR: begin
            blank_screen();
         end
         OP_READ: begin
            if (int'(item.cell_index) < CELLS) data = screen_model[item.cell_index];
         end
      endcase
      result.cursor_x      = X_W'(cur_col);
      result.cursor_y      = Y_W'(cur_row);
      result.cursor_offset = OFFSET_W'(cur_row * COLS + cur_col);
      result.read_data     = data;
   endtask

   task automatic build_random(output req_type item);
      int pick;
      int offset;
      bit scrolls;
      item.op         = OP_PUT;
      item.char_code  = CHAR_W'($urandom_range(0, 255));
      item.new_x      = X_W'($urandom_range(0, 127));
      item.new_y      = Y_W'($urandom_range(0, 31));
      item.cell_index = INDEX_W'($urandom_range(0, 2047));
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
         item.op = OP_PUT;
         pick = $urandom_range(0, 99);
         if (pick < 12) item.char_code = CH_NEWLINE;
         else if (pick < 18) item.char_code = CH_BACKSPACE;
         else if (pick < 22) item.char_code = CH_RETURN;
      end else if (pick < 73) begin
         item.op = OP_SET;
      end else if (pick < 98 || clear_count >= CLEAR_CAP) begin
         item.op = OP_READ;
         pick = $urandom_range(0, 9);
         offset = cur_row * COLS + cur_col;
         if (pick < 5) begin
            offset = offset - $urandom_range(0, 3);
            item.cell_index = INDEX_W'((offset < 0) ? 0 : offset);
         end else if (pick < 9) begin
            item.cell_index = INDEX_W'($urandom_range(0, CELLS - 1));
         end
      end else begin
         item.op = OP_CLEAR;
         clear_count++;
      end
      scrolls = (item.op == OP_PUT) && (cur_row == ROWS - 1) &&
                (item.char_code == CH_NEWLINE ||
                 (item.char_code != CH_BACKSPACE && item.char_code != CH_RETURN &&
                  cur_col == COLS - 1));
      if (scrolls && scroll_count >= SCROLL_CAP) item.op = OP_SET;
   endtask

   task automatic send_item(input req_type item, input bit drop_after);
      int gap;
      gap = 0;
      if (!quiet && !drop_after && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, item.cell_index, item.new_y, item.new_x, item.char_code};
      req_tuser  <= item.op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (drop_after || gap != 0) req_tvalid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch: %s got %0h want %0h", what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp.cursor_x      = rsp_tdata[6:0];
         got_rsp.cursor_y      = rsp_tdata[11:7];
         got_rsp.cursor_offset = rsp_tdata[22:12];
         got_rsp.read_data     = rsp_tdata[38:23];
         if (pending_rsp.size() == 0) begin
            report_mismatch("result beat with nothing pending", int'(rsp_tdata[38:0]), 0);
         end else begin
            want_rsp = pending_rsp.pop_front();
            if (got_rsp.cursor_x != want_rsp.cursor_x)
               report_mismatch("cursor_x", got_rsp.cursor_x, want_rsp.cursor_x);
            if (got_rsp.cursor_y != want_rsp.cursor_y)
               report_mismatch("cursor_y", got_rsp.cursor_y, want_rsp.cursor_y);
            if (got_rsp.cursor_offset != want_rsp.cursor_offset)
               report_mismatch("cursor_offset", got_rsp.cursor_offset, want_rsp.cursor_offset);
            if (got_rsp.read_data != want_rsp.read_data)
               report_mismatch("read_data", got_rsp.read_data, want_rsp.read_data);
         end
      end
   end

   initial begin
      int stall;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clock);
            hold_request = 1'b0;
            rsp_tready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall = $urandom_range(1, 7);
            repeat (stall) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      req_type  item;
      rsp_type  want;
      stim_row_t row;
      logic [ATTR_W-1:0] attr_next;
      blank_screen();
      attr_reg       = ATTR_RESET;
      scroll_count   = 0;
      clear_count    = 0;
      mismatch_count = 0;
      quiet          = 1'b0;
      hold_request   = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_ROWS; r++) begin
         row = DIRECTED[r];
         item.op         = row.op;
         item.char_code  = row.ch;
         item.new_x      = row.x;
         item.new_y      = row.y;
         item.cell_index = row.idx;
         console_apply(item, want);
         if (row.typed) begin
            want.cursor_x      = row.wx;
            want.cursor_y      = row.wy;
            want.cursor_offset = row.woff;
            want.read_data     = row.wdata;
         end
         pending_rsp.push_back(want);
         send_item(item, r == DIR_ROWS - 1);
      end

      for (int p = 0; p < PHASES; p++) begin
         while (pending_rsp.size() != 0) @(posedge clock);
         repeat (8) @(posedge clock);
         if (p == 0) attr_next = 8'hFF;
         else if (p == 1) attr_next = 8'h00;
         else attr_next = ATTR_W'($urandom_range(0, 255));
         csr_wr_en   <= 1'b1;
         csr_wr_data <= attr_next;
         @(posedge clock);
         csr_wr_en <= 1'b0;
         attr_reg = attr_next;
         if (p == 1) hold_request = 1'b1;
         if (p == PHASES - 1) quiet = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            build_random(item);
            console_apply(item, want);
            pending_rsp.push_back(want);
            send_item(item, n == PHASE_ITEMS - 1);
         end
      end

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
